// ===== hdl/gdjs_pkg.sv =====
// Shared widths, bus layout and defaults for the greedy deadline job scheduler.
// No dependencies; used by every other file of the block except gdjs_ram.
package gdjs_pkg;

   localparam int TAG_W     = 32;
   localparam int DUE_IN_W  = 6;
   localparam int GAIN_W    = 16;
   localparam int TOTAL_W   = 21;
   localparam int SLOTNUM_W = 6;

   localparam int MAX_JOBS_DEF  = 64;
   localparam int MAX_SLOTS_DEF = 32;

   // req_tdata: job_tag, due_slot, gain, then zero fill
   localparam int REQ_TAG_LSB  = 0;
   localparam int REQ_DUE_LSB  = REQ_TAG_LSB + TAG_W;
   localparam int REQ_GAIN_LSB = REQ_DUE_LSB + DUE_IN_W;
   localparam int REQ_USED_W   = REQ_GAIN_LSB + GAIN_W;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // rsp_tdata: slot_number, chosen_tag, chosen_gain, running_total, then zero fill
   localparam int RSP_SLOT_LSB  = 0;
   localparam int RSP_TAG_LSB   = RSP_SLOT_LSB + SLOTNUM_W;
   localparam int RSP_GAIN_LSB  = RSP_TAG_LSB + TAG_W;
   localparam int RSP_TOTAL_LSB = RSP_GAIN_LSB + GAIN_W;
   localparam int RSP_USED_W    = RSP_TOTAL_LSB + TOTAL_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // rsp_tuser: slot_filled, jobs_dropped
   localparam int TUSER_FILLED  = 0;
   localparam int TUSER_DROPPED = 1;
   localparam int RSP_TUSER_W   = 2;

endpackage

// ===== hdl/greedy_deadline_job_scheduler_unit.sv =====
// Top level of the greedy deadline job scheduler: sequencer plus job and slot RAMs.
// Depends on gdjs_pkg, gdjs_ram and gdjs_ctrl.

// Jobs stream in on req_ one word per cycle (req_tready stays high while loading) and are
// written into the job RAM; up to MAX_JOBS are kept, later ones are dropped and flagged.
// The word with req_tlast starts scheduling and req_tready drops until the last slot
// result has been handed to the output register. Ranking shares the single read port of
// the job RAM: each job in turn costs one scan over the n stored jobs (n reads, the last
// compare, the pick), then the mark write and a walk down from its capped deadline past
// each occupied slot; a final scan that finds no job ends the phase. Output takes, per
// slot, a slot RAM read, a job RAM read and a result load, plus any rsp_ back-pressure.
// A new load may start while the last result still waits in the output register.
module greedy_deadline_job_scheduler_unit #(
   parameter int MAX_JOBS  = gdjs_pkg::MAX_JOBS_DEF,
   parameter int MAX_SLOTS = gdjs_pkg::MAX_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // job_tag[31:0], due_slot[37:32], gain[53:38], zero fill
   input  logic [gdjs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tlast,   // final_job
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // slot_number[5:0], chosen_tag[37:6], chosen_gain[53:38], running_total[74:54], zero fill
   output logic [gdjs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // slot_filled[0], jobs_dropped[1]
   output logic [gdjs_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast    // last_slot
);

   localparam int IW  = $clog2(MAX_JOBS);
   localparam int SW  = $clog2(MAX_SLOTS + 1);
   localparam int SAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int JW  = 1 + SW + gdjs_pkg::GAIN_W + gdjs_pkg::TAG_W;

   logic           job_wr_en;
   logic [IW-1:0]  job_wr_addr;
   logic [JW-1:0]  job_wr_data;
   logic           job_rd_en;
   logic [IW-1:0]  job_rd_addr;
   logic [JW-1:0]  job_rd_data;
   logic           slot_wr_en;
   logic [SAW-1:0] slot_wr_addr;
   logic [IW-1:0]  slot_wr_data;
   logic           slot_rd_en;
   logic [SAW-1:0] slot_rd_addr;
   logic [IW-1:0]  slot_rd_data;

   gdjs_ram #(
      .DEPTH  (MAX_JOBS),
      .DATA_W (JW),
      .ADDR_W (IW)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (job_wr_en),
      .wr_addr (job_wr_addr),
      .wr_data (job_wr_data),
      .rd_en   (job_rd_en),
      .rd_addr (job_rd_addr),
      .rd_data (job_rd_data)
   );

   gdjs_ram #(
      .DEPTH  (MAX_SLOTS),
      .DATA_W (IW),
      .ADDR_W (SAW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   gdjs_ctrl #(
      .MAX_JOBS  (MAX_JOBS),
      .MAX_SLOTS (MAX_SLOTS),
      .IW        (IW),
      .SAW       (SAW),
      .JW        (JW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .job_wr_en    (job_wr_en),
      .job_wr_addr  (job_wr_addr),
      .job_wr_data  (job_wr_data),
      .job_rd_en    (job_rd_en),
      .job_rd_addr  (job_rd_addr),
      .job_rd_data  (job_rd_data),
      .slot_wr_en   (slot_wr_en),
      .slot_wr_addr (slot_wr_addr),
      .slot_wr_data (slot_wr_data),
      .slot_rd_en   (slot_rd_en),
      .slot_rd_addr (slot_rd_addr),
      .slot_rd_data (slot_rd_data)
   );

endmodule

// ===== hdl/gdjs_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; holds the job words and the slot owner indexes.
module gdjs_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 8,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gdjs_ctrl.sv =====
// Sequencer of the scheduler: load, rank-by-scan, slot placement and result output.
// Depends on gdjs_pkg; drives the job RAM and the slot owner RAM of the top level.
module gdjs_ctrl #(
   parameter int MAX_JOBS  = gdjs_pkg::MAX_JOBS_DEF,
   parameter int MAX_SLOTS = gdjs_pkg::MAX_SLOTS_DEF,
   parameter int IW        = $clog2(MAX_JOBS),
   parameter int SAW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   parameter int JW        = 1 + $clog2(MAX_SLOTS + 1) + gdjs_pkg::GAIN_W + gdjs_pkg::TAG_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gdjs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gdjs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [gdjs_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                               rsp_tlast,
   // job RAM
   output logic                               job_wr_en,
   output logic [IW-1:0]                      job_wr_addr,
   output logic [JW-1:0]                      job_wr_data,
   output logic                               job_rd_en,
   output logic [IW-1:0]                      job_rd_addr,
   input  logic [JW-1:0]                      job_rd_data,
   // slot owner RAM
   output logic                               slot_wr_en,
   output logic [SAW-1:0]                     slot_wr_addr,
   output logic [IW-1:0]                      slot_wr_data,
   output logic                               slot_rd_en,
   output logic [SAW-1:0]                     slot_rd_addr,
   input  logic [IW-1:0]                      slot_rd_data
);

   localparam int CW = $clog2(MAX_JOBS + 1);
   localparam int SW = $clog2(MAX_SLOTS + 1);

   typedef struct packed {
      logic                        done;
      logic [SW-1:0]               due;
      logic [gdjs_pkg::GAIN_W-1:0] gain;
      logic [gdjs_pkg::TAG_W-1:0]  tag;
   } job_word_type;

   typedef enum logic [6:0] {
      ST_LOAD    = 7'b0000001,
      ST_SCAN    = 7'b0000010,
      ST_MARK    = 7'b0000100,
      ST_PLACE   = 7'b0001000,
      ST_SLOT_RD = 7'b0010000,
      ST_JOB_RD  = 7'b0100000,
      ST_OUT     = 7'b1000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [SW-1:0]                latest_ff, latest_in;
   logic                         over_ff, over_in;
   logic [MAX_SLOTS-1:0]         used_ff, used_in;
   logic [CW-1:0]                scan_ff, scan_in;
   logic                         rdv_ff, rdv_in;
   logic [IW-1:0]                rdidx_ff, rdidx_in;
   logic                         found_ff, found_in;
   job_word_type                 best_ff, best_in;
   logic [IW-1:0]                best_idx_ff, best_idx_in;
   logic [SW-1:0]                k_ff, k_in;
   logic [SW-1:0]                s_ff, s_in;
   logic [gdjs_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [gdjs_pkg::SLOTNUM_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                           rsp_filled_ff, rsp_filled_in;
   logic [gdjs_pkg::TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [gdjs_pkg::GAIN_W-1:0]    rsp_gain_ff, rsp_gain_in;
   logic [gdjs_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                           rsp_drop_ff, rsp_drop_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [gdjs_pkg::TAG_W-1:0]    req_tag;
   logic [gdjs_pkg::DUE_IN_W-1:0] req_due;
   logic [gdjs_pkg::GAIN_W-1:0]   req_gain;
   logic [gdjs_pkg::DUE_IN_W:0]   due_ext;
   logic [SW-1:0]                 due_sat;
   logic                          accept;
   logic                          room;
   logic                          issue;
   logic                          out_free;
   logic                          k_free;
   logic                          s_used;
   job_word_type                  rd_word;
   job_word_type                  load_word;
   job_word_type                  mark_word;
   logic [gdjs_pkg::GAIN_W-1:0]   out_gain;
   logic [gdjs_pkg::TAG_W-1:0]    out_tag;
   logic [gdjs_pkg::TOTAL_W-1:0]  total_next;

   assign req_tag  = req_tdata[gdjs_pkg::REQ_TAG_LSB +: gdjs_pkg::TAG_W];
   assign req_due  = req_tdata[gdjs_pkg::REQ_DUE_LSB +: gdjs_pkg::DUE_IN_W];
   assign req_gain = req_tdata[gdjs_pkg::REQ_GAIN_LSB +: gdjs_pkg::GAIN_W];

   assign due_ext = {1'b0, req_due};
   assign due_sat = (due_ext > (gdjs_pkg::DUE_IN_W + 1)'(MAX_SLOTS)) ? SW'(MAX_SLOTS)
                                                                      : SW'(due_ext);

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign room       = (count_ff < CW'(MAX_JOBS));
   assign issue      = (scan_ff < count_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_word    = job_word_type'(job_rd_data);
   assign k_free     = !used_ff[SAW'(k_ff - 1'b1)];
   assign s_used     = used_ff[SAW'(s_ff - 1'b1)];
   assign out_gain   = s_used ? rd_word.gain : '0;
   assign out_tag    = s_used ? rd_word.tag : '0;
   assign total_next = total_ff + gdjs_pkg::TOTAL_W'(out_gain);

   always_comb begin
      load_word      = '0;
      load_word.due  = due_sat;
      load_word.gain = req_gain;
      load_word.tag  = req_tag;
      mark_word      = best_ff;
      mark_word.done = 1'b1;
   end

   // memory ports
   assign job_wr_en    = (accept && room) || (state_ff == ST_MARK);
   assign job_wr_addr  = (state_ff == ST_LOAD) ? count_ff[IW-1:0] : best_idx_ff;
   assign job_wr_data  = (state_ff == ST_LOAD) ? load_word : mark_word;
   assign job_rd_en    = ((state_ff == ST_SCAN) && issue) || (state_ff == ST_JOB_RD);
   assign job_rd_addr  = (state_ff == ST_SCAN) ? scan_ff[IW-1:0] : slot_rd_data;
   assign slot_wr_en   = (state_ff == ST_PLACE) && (k_ff != '0) && k_free;
   assign slot_wr_addr = SAW'(k_ff - 1'b1);
   assign slot_wr_data = best_idx_ff;
   assign slot_rd_en   = (state_ff == ST_SLOT_RD);
   assign slot_rd_addr = SAW'(s_ff - 1'b1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      latest_in     = latest_ff;
      over_in       = over_ff;
      used_in       = used_ff;
      scan_in       = scan_ff;
      rdv_in        = 1'b0;
      rdidx_in      = rdidx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      k_in          = k_ff;
      s_in          = s_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_filled_in = rsp_filled_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + 1'b1;
                  if (due_sat > latest_ff) begin
                     latest_in = due_sat;
                  end
               end else begin
                  over_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, the returned word compared in the cycle after
            if (issue) begin
               rdv_in   = 1'b1;
               rdidx_in = scan_ff[IW-1:0];
               scan_in  = scan_ff + 1'b1;
            end
            if (rdv_ff) begin
               if (!rd_word.done && (!found_ff || rd_word.gain > best_ff.gain)) begin
                  best_in     = rd_word;
                  best_idx_in = rdidx_ff;
                  found_in    = 1'b1;
               end
            end else if (!issue) begin
               if (found_ff) begin
                  state_in = ST_MARK;
               end else if (latest_ff == '0) begin
                  state_in  = ST_LOAD;
                  count_in  = '0;
                  latest_in = '0;
                  over_in   = 1'b0;
                  used_in   = '0;
               end else begin
                  state_in = ST_SLOT_RD;
                  s_in     = SW'(1);
                  total_in = '0;
               end
            end
         end
         ST_MARK: begin
            k_in     = (best_ff.due > latest_ff) ? latest_ff : best_ff.due;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            // walk down from the capped deadline to the latest free slot
            if (k_ff == '0 || k_free) begin
               if (k_ff != '0) begin
                  used_in[SAW'(k_ff - 1'b1)] = 1'b1;
               end
               state_in = ST_SCAN;
               scan_in  = '0;
               found_in = 1'b0;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         ST_SLOT_RD: begin
            state_in = ST_JOB_RD;
         end
         ST_JOB_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = gdjs_pkg::SLOTNUM_W'(s_ff);
               rsp_filled_in = s_used;
               rsp_tag_in    = out_tag;
               rsp_gain_in   = out_gain;
               rsp_total_in  = total_next;
               rsp_drop_in   = over_ff;
               rsp_last_in   = (s_ff == latest_ff);
               total_in      = total_next;
               if (s_ff == latest_ff) begin
                  state_in  = ST_LOAD;
                  count_in  = '0;
                  latest_in = '0;
                  over_in   = 1'b0;
                  used_in   = '0;
               end else begin
                  s_in     = s_ff + 1'b1;
                  state_in = ST_SLOT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         latest_ff    <= '0;
         over_ff      <= 1'b0;
         used_ff      <= '0;
         rdv_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         latest_ff    <= latest_in;
         over_ff      <= over_in;
         used_ff      <= used_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      rdidx_ff      <= rdidx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      k_ff          <= k_in;
      s_ff          <= s_in;
      total_ff      <= total_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_filled_ff <= rsp_filled_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[gdjs_pkg::RSP_SLOT_LSB +: gdjs_pkg::SLOTNUM_W] = rsp_slot_ff;
      rsp_tdata[gdjs_pkg::RSP_TAG_LSB +: gdjs_pkg::TAG_W]      = rsp_tag_ff;
      rsp_tdata[gdjs_pkg::RSP_GAIN_LSB +: gdjs_pkg::GAIN_W]    = rsp_gain_ff;
      rsp_tdata[gdjs_pkg::RSP_TOTAL_LSB +: gdjs_pkg::TOTAL_W]  = rsp_total_ff;
      rsp_tuser = '0;
      rsp_tuser[gdjs_pkg::TUSER_FILLED]  = rsp_filled_ff;
      rsp_tuser[gdjs_pkg::TUSER_DROPPED] = rsp_drop_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/gdjs_checker.sv =====
// Port-level checks for the greedy deadline job scheduler, bound to its top level.
// Depends on gdjs_pkg and greedy_deadline_job_scheduler_unit.
module gdjs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [gdjs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [gdjs_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input logic                             rsp_tlast
);

   localparam int PICK_LSB = gdjs_pkg::RSP_TAG_LSB;
   localparam int PICK_W   = gdjs_pkg::TAG_W + gdjs_pkg::GAIN_W;

   // a held result word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // the final job word closes the load window
   a_load_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still open after final job word");

   // a pending non-final slot result means scheduling is still running
   a_no_load_mid_output: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input open while slot results remain");

   // an empty slot carries no tag and no gain
   a_empty_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[gdjs_pkg::TUSER_FILLED]
         |-> rsp_tdata[PICK_LSB +: PICK_W] == '0)
      else $error("empty slot carries job data");

endmodule

bind greedy_deadline_job_scheduler_unit gdjs_checker u_gdjs_checker (.*);

// ===== tb/gdjs_tb_pkg.sv =====
// Slot word type and scoreboard for the greedy deadline job scheduler testbench.
// Depends on gdjs_pkg for field widths and store sizes.
package gdjs_tb_pkg;

   import gdjs_pkg::*;

   localparam int JOB_DEPTH  = MAX_JOBS_DEF;
   localparam int SLOT_DEPTH = MAX_SLOTS_DEF;

   typedef struct packed {
      logic [SLOTNUM_W-1:0] slot_num;
      logic                 filled;
      logic [TAG_W-1:0]     tag;
      logic [GAIN_W-1:0]    gain;
      logic [TOTAL_W-1:0]   total;
      logic                 dropped;
      logic                 last;
   } slot_word_type;

   class slot_scoreboard;
      bit [TAG_W-1:0]    tag_mem[JOB_DEPTH];
      bit [DUE_IN_W-1:0] due_mem[JOB_DEPTH];
      bit [GAIN_W-1:0]   gain_mem[JOB_DEPTH];
      int unsigned       n_jobs;
      int unsigned       top_due;
      bit                overflow;
      slot_word_type     expected_slots[$];
      int unsigned       failures;

      // Called for every accepted job word; the final word builds the slot plan.
      function void note_job(bit [TAG_W-1:0] tag, bit [DUE_IN_W-1:0] due,
                             bit [GAIN_W-1:0] gain, bit final_job);
         int unsigned due_sat;
         due_sat = (due > SLOT_DEPTH) ? SLOT_DEPTH : due;
         if (n_jobs < JOB_DEPTH) begin
            tag_mem[n_jobs]  = tag;
            due_mem[n_jobs]  = DUE_IN_W'(due_sat);
            gain_mem[n_jobs] = gain;
            n_jobs++;
            if (due_sat > top_due) top_due = due_sat;
         end else begin
            overflow = 1'b1;
         end
         if (final_job) schedule_set();
      endfunction

      function void schedule_set();
         int               rank[JOB_DEPTH];
         int               owner[SLOT_DEPTH+1];
         bit               taken[SLOT_DEPTH+1];
         int               j, k, cur;
         bit [TOTAL_W-1:0] sum;
         slot_word_type    w;
         foreach (taken[s]) taken[s] = 1'b0;
         // stable insertion sort, highest gain first
         for (int i = 0; i < n_jobs; i++) begin
            cur = i;
            j = i;
            while (j > 0 && gain_mem[rank[j-1]] < gain_mem[cur]) begin
               rank[j] = rank[j-1];
               j--;
            end
            rank[j] = cur;
         end
         for (int i = 0; i < n_jobs; i++) begin
            k = (due_mem[rank[i]] > top_due) ? top_due : due_mem[rank[i]];
            while (k >= 1) begin
               if (!taken[k]) begin
                  taken[k] = 1'b1;
                  owner[k] = rank[i];
                  break;
               end
               k--;
            end
         end
         sum = '0;
         for (int s = 1; s <= top_due; s++) begin
            w = '0;
            w.slot_num = SLOTNUM_W'(s);
            w.filled   = taken[s];
            if (taken[s]) begin
               w.tag  = tag_mem[owner[s]];
               w.gain = gain_mem[owner[s]];
            end
            sum += w.gain;
            w.total   = sum;
            w.dropped = overflow;
            w.last    = (s == top_due);
            expected_slots.push_back(w);
         end
         n_jobs   = 0;
         top_due  = 0;
         overflow = 1'b0;
      endfunction

      function void check_slot(slot_word_type got);
         slot_word_type want;
         bit            bad;
         if (expected_slots.size() == 0) begin
            report_miss("unexpected slot word", '0, got);
            return;
         end
         want = expected_slots.pop_front();
         bad = (got.slot_num !== want.slot_num) || (got.filled !== want.filled) ||
               (got.tag !== want.tag) || (got.gain !== want.gain) ||
               (got.total !== want.total) || (got.dropped !== want.dropped) ||
               (got.last !== want.last);
         if (bad) report_miss("slot word mismatch", want, got);
      endfunction

      function void report_miss(string why, slot_word_type want, slot_word_type got);
         failures++;
         if (failures <= 10) begin
            $display("%s", why);
            $display("  exp slot=%0d filled=%b tag=%h gain=%h total=%0d dropped=%b last=%b",
                     want.slot_num, want.filled, want.tag, want.gain, want.total,
                     want.dropped, want.last);
            $display("  got slot=%0d filled=%b tag=%h gain=%h total=%0d dropped=%b last=%b",
                     got.slot_num, got.filled, got.tag, got.gain, got.total,
                     got.dropped, got.last);
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// Top of the greedy deadline job scheduler testbench: clock, reset, job and slot drivers.
// Depends on gdjs_pkg, gdjs_tb_pkg and greedy_deadline_job_scheduler_unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gdjs_pkg::*;
   import gdjs_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8000;   // worst ranking pass of a full store plus output

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   slot_scoreboard sb;
   slot_word_type  seen_word;
   int unsigned    cycle_count;
   bit             req_eager;   // sender runs without gaps
   bit             rsp_eager;   // receiver runs without stalls

   always #6 clock = ~clock;

   greedy_deadline_job_scheduler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic send_job(bit [TAG_W-1:0] tag, bit [DUE_IN_W-1:0] due,
                           bit [GAIN_W-1:0] gain, bit final_job);
      int unsigned            gap;
      logic [REQ_TDATA_W-1:0] word;
      gap = req_eager ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word = '0;
      word[REQ_TAG_LSB +: TAG_W]     = tag;
      word[REQ_DUE_LSB +: DUE_IN_W]  = due;
      word[REQ_GAIN_LSB +: GAIN_W]   = gain;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tlast  <= final_job;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_job(tag, due, gain, final_job);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen_word.slot_num = rsp_tdata[RSP_SLOT_LSB +: SLOTNUM_W];
         seen_word.filled   = rsp_tuser[TUSER_FILLED];
         seen_word.tag      = rsp_tdata[RSP_TAG_LSB +: TAG_W];
         seen_word.gain     = rsp_tdata[RSP_GAIN_LSB +: GAIN_W];
         seen_word.total    = rsp_tdata[RSP_TOTAL_LSB +: TOTAL_W];
         seen_word.dropped  = rsp_tuser[TUSER_DROPPED];
         seen_word.last     = rsp_tlast;
         sb.check_slot(seen_word);
      end
   end

   initial begin : slot_sink
      int unsigned stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_eager = ~rsp_eager;
         stall = rsp_eager ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : job_source
      int unsigned       n_sent, set_idx, set_len, style;
      bit [DUE_IN_W-1:0] due;
      bit [GAIN_W-1:0]   gain;
      sb = new;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single job, all-ones tag and gain
      req_eager = 1'b0;
      send_job(32'hFFFF_FFFF, 6'd1, 16'hFFFF, 1'b1);
      // only job has deadline zero: no slots, no words out
      send_job(32'h0, 6'd0, 16'h0, 1'b1);
      // equal gains keep arrival order, saturated deadlines, skipped job, zero-gain fill
      req_eager = 1'b1;
      send_job(32'h1111_1111, 6'd2,  16'd100,   1'b0);
      send_job(32'h2222_2222, 6'd2,  16'd100,   1'b0);
      send_job(32'h3333_3333, 6'd2,  16'd50,    1'b0);
      send_job(32'h4444_4444, 6'd63, 16'd0,     1'b0);
      send_job(32'h5555_5555, 6'd33, 16'hFFFF,  1'b0);
      send_job(32'h0,         6'd0,  16'd7,     1'b1);
      // more jobs than slots below the deadline
      req_eager = 1'b0;
      send_job(32'hA0A0_0001, 6'd3, 16'd5, 1'b0);
      send_job(32'hA0A0_0002, 6'd3, 16'd6, 1'b0);
      send_job(32'hA0A0_0003, 6'd3, 16'd7, 1'b0);
      send_job(32'hA0A0_0004, 6'd3, 16'd8, 1'b1);
      // alternating bit patterns
      send_job(32'hAAAA_AAAA, 6'd42, 16'hAAAA, 1'b0);
      send_job(32'h5555_5555, 6'd21, 16'h5555, 1'b1);

      n_sent  = 0;
      set_idx = 0;
      while (n_sent < 290) begin
         req_eager = ($urandom_range(0, 3) == 0);
         style = $urandom_range(0, 3);
         case (set_idx)
            3:       set_len = JOB_DEPTH;                            // exactly full
            6:       set_len = SLOT_DEPTH + 2;                       // every slot at max gain
            9:       set_len = JOB_DEPTH + 1;                        // final word dropped
            15:      set_len = JOB_DEPTH + 2 + $urandom_range(0, 4);
            default: set_len = $urandom_range(1, 10);
         endcase
         for (int i = 0; i < set_len; i++) begin
            if (set_idx == 6) begin
               due  = DUE_IN_W'($urandom_range(SLOT_DEPTH, 63));
               gain = 16'hFFFF;
            end else begin
               case ($urandom_range(0, 9))
                  0:       due = 6'd0;
                  1, 2:    due = DUE_IN_W'($urandom_range(0, 63));
                  3, 4:    due = DUE_IN_W'($urandom_range(1, SLOT_DEPTH));
                  default: due = DUE_IN_W'($urandom_range(1, (set_len < 30) ? set_len + 2
                                                                            : SLOT_DEPTH));
               endcase
               case (style)
                  0:       gain = GAIN_W'($urandom_range(0, 3));   // plenty of ties
                  1: begin
                     case ($urandom_range(0, 2))
                        0:       gain = 16'h0;
                        1:       gain = 16'hFFFF;
                        default: gain = GAIN_W'($urandom);
                     endcase
                  end
                  default: gain = GAIN_W'($urandom);
               endcase
            end
            send_job($urandom, due, gain, i == set_len - 1);
         end
         n_sent += set_len;
         set_idx++;
      end
      req_tvalid <= 1'b0;

      while (sb.expected_slots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
